// ----- rtl/obss_pkg.sv -----
// ----------------------------------------------------------------------------
// obss_pkg
// types, codes and widths shared by the ordered byte set store
// ----------------------------------------------------------------------------
package obss_pkg;

    localparam int unsigned ITEM_W       = 8;
    localparam int unsigned IDX_W        = 6;
    localparam int unsigned COUNT_OUT_W  = 7;
    localparam int unsigned DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_QUERY = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    // command held while the chain evaluates it
    typedef struct packed {
        opcode_t            opcode;
        logic [ITEM_W-1:0]  item_byte;
        logic [IDX_W-1:0]   entry_index;
    } cmd_t;

    // update strobes broadcast back into every cell
    typedef struct packed {
        logic do_add;
        logic do_del;
    } commit_t;

    // neighbor link: match seen so far and selected read data
    typedef struct packed {
        logic               hit;
        logic [ITEM_W-1:0]  value;
    } link_t;

endpackage

// ----- rtl/obss_req_if.sv -----
// ----------------------------------------------------------------------------
// obss_req_if
// request channel: one operation word with valid/ready handshake
// ----------------------------------------------------------------------------
interface obss_req_if;
    import obss_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [ITEM_W-1:0]  item_byte;
    logic [IDX_W-1:0]   entry_index;

    modport source (output valid, output opcode, output item_byte, output entry_index,
                    input ready);
    modport sink   (input valid, input opcode, input item_byte, input entry_index,
                    output ready);
endinterface

// ----- rtl/obss_rsp_if.sv -----
// ----------------------------------------------------------------------------
// obss_rsp_if
// response channel: one result word with valid/ready handshake
// ----------------------------------------------------------------------------
interface obss_rsp_if;
    import obss_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [ITEM_W-1:0]       entry_value;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic [1:0]              status;

    modport source (output valid, output found, output entry_value, output entry_count,
                    output status, input ready);
    modport sink   (input valid, input found, input entry_value, input entry_count,
                    input status, output ready);
endinterface

// ----- rtl/obss_cell.sv -----
// ----------------------------------------------------------------------------
// obss_cell
// one storage slot: compare, read select, append write and shift-down on delete
// ----------------------------------------------------------------------------
module obss_cell #(
    parameter int unsigned POS   = 0,
    parameter int unsigned CNT_W = 7
) (
    input  logic                        clk,
    input  obss_pkg::cmd_t              cmd,
    input  obss_pkg::commit_t           commit,
    input  logic [CNT_W-1:0]            count,
    input  obss_pkg::link_t             link_in,
    output obss_pkg::link_t             link_out,
    input  logic [obss_pkg::ITEM_W-1:0] neighbor_entry,
    output logic [obss_pkg::ITEM_W-1:0] entry
);
    import obss_pkg::*;

    localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

    logic [ITEM_W-1:0] entry_reg;
    logic [ITEM_W-1:0] entry_next;
    logic              live;
    logic              match;
    logic              sel;

    assign live  = (POS_C < count);
    assign match = live && (entry_reg == cmd.item_byte);
    assign sel   = (32'(cmd.entry_index) == 32'(POS));

    // hit ripples upward: every slot at or above the match moves down
    assign link_out.hit   = link_in.hit | match;
    assign link_out.value = link_in.value | (sel ? entry_reg : '0);

    always_comb
    begin
        entry_next = entry_reg;
        if (commit.do_add && (count == POS_C))
        begin
            entry_next = cmd.item_byte;
        end
        else if (commit.do_del && link_out.hit)
        begin
            entry_next = neighbor_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/ordered_byte_set_store.sv -----
// ----------------------------------------------------------------------------
// ordered_byte_set_store
// insertion-ordered set of distinct bytes built as a row of compare cells
// ----------------------------------------------------------------------------
// Holds up to CAPACITY distinct bytes in the order they were first added. Each
// request word carries an opcode (add, delete, membership query, read at
// index) and gives exactly one response word with found, the read value, the
// entry count after the operation and a status code. The store is a row of
// CAPACITY identical cells; each cell holds one byte, compares it against the
// request byte, and passes a match flag and read data on to the next cell.
// A delete moves every entry above the matching cell down by one slot at
// once, each cell taking its upper neighbor's byte. Throughput is one
// operation per clock while the response side stays ready. The request sits
// in the command register after its accept edge, is evaluated there and is
// captured into the response register once that register is free. The
// critical path is the match/read ripple through all CAPACITY cells. While a
// response waits, one more request can be taken into the command register;
// after that the request side stalls until the response is taken. Slot
// contents have no reset; only slots below the count are ever looked at, so
// no clearing pass is needed after reset. entry_count reports the low seven
// bits of the count.
// ----------------------------------------------------------------------------
module ordered_byte_set_store #(
    parameter int unsigned CAPACITY = obss_pkg::DEF_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    obss_req_if.sink     req,
    obss_rsp_if.source   rsp
);
    import obss_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // command stage
    logic     cmd_valid_reg;
    logic     cmd_valid_next;
    cmd_t     cmd_reg;

    // response stage
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic                    found_reg;
    logic [ITEM_W-1:0]       value_reg;
    logic [COUNT_OUT_W-1:0]  count_out_reg;
    status_t                 status_reg;

    // occupancy
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // cell row
    link_t             link [CAPACITY+1];
    logic [ITEM_W-1:0] entry_q [CAPACITY];
    commit_t           commit;

    // handshake
    logic rsp_free;
    logic advance;
    logic req_take;

    // evaluation of the held command
    logic              hit;
    logic              idx_ok;
    logic              found_calc;
    logic [ITEM_W-1:0] value_calc;
    status_t           status_calc;

    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign advance   = cmd_valid_reg && rsp_free;
    assign req.ready = !cmd_valid_reg || rsp_free;
    assign req_take  = req.valid && req.ready;

    // ---- cell row ----
    assign link[0] = '0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [ITEM_W-1:0] upper;
        if (k == CAPACITY - 1)
        begin : g_top
            assign upper = entry_q[k];
        end
        else
        begin : g_mid
            assign upper = entry_q[k+1];
        end

        obss_cell #(
            .POS   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk            (clk),
            .cmd            (cmd_reg),
            .commit         (commit),
            .count          (count_reg),
            .link_in        (link[k]),
            .link_out       (link[k+1]),
            .neighbor_entry (upper),
            .entry          (entry_q[k])
        );
    end

    // ---- decide the operation ----
    assign hit    = link[CAPACITY].hit;
    assign idx_ok = (CMP_W'(cmd_reg.entry_index) < CMP_W'(count_reg));

    always_comb
    begin
        commit      = '0;
        found_calc  = 1'b0;
        value_calc  = '0;
        status_calc = ST_OK;
        count_next  = count_reg;
        unique case (cmd_reg.opcode)
            OP_ADD:
            begin
                if (hit)
                begin
                    found_calc = 1'b1;
                end
                else if (count_reg >= CAP_C)
                begin
                    status_calc = ST_FULL;
                end
                else
                begin
                    commit.do_add = advance;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_DEL:
            begin
                if (hit)
                begin
                    found_calc    = 1'b1;
                    commit.do_del = advance;
                    count_next    = count_reg - 1'b1;
                end
                else
                begin
                    status_calc = ST_NOT_FOUND;
                end
            end
            OP_QUERY:
            begin
                found_calc = hit;
            end
            OP_READ:
            begin
                if (idx_ok)
                begin
                    value_calc = link[CAPACITY].value;
                end
                else
                begin
                    status_calc = ST_BAD_INDEX;
                end
            end
            default:
            begin
                status_calc = ST_OK;
            end
        endcase
    end

    // ---- control registers ----
    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (req_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                count_reg <= count_next;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg.opcode      <= opcode_t'(req.opcode);
            cmd_reg.item_byte   <= req.item_byte;
            cmd_reg.entry_index <= req.entry_index;
        end
        if (advance)
        begin
            found_reg     <= found_calc;
            value_reg     <= value_calc;
            count_out_reg <= COUNT_OUT_W'(count_next);
            status_reg    <= status_calc;
        end
    end

    // ---- response port ----
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.entry_value = value_reg;
    assign rsp.entry_count = count_out_reg;
    assign rsp.status      = status_reg;

`ifndef ASSERT_OFF
    // occupancy never runs past the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("count beyond capacity");

    // an accepted append grows the count by exactly one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        commit.do_add |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow count");

    // a delete only happens on a match and shrinks the count by one
    a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        commit.do_del |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not shrink count");

    // append and delete never fire together
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit.do_add && commit.do_del))
        else $error("append and delete at once");

    // a rejected read returns zero data
    a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (status_reg == ST_BAD_INDEX) |-> value_reg == '0)
        else $error("bad index returned data");
`endif

endmodule
